// ----- rtl/slq_pkg.sv -----
// ----------------------------------------------------------------------------
// Spectral line quantizer package
// Widths, constants, shared types and helper functions for the quantizer.
// ----------------------------------------------------------------------------
package slq_pkg;

  localparam int COEF_BITS = 24;
  localparam int FRAC_BITS = 16;
  localparam int QUANT_MAX = 8191;

  localparam int BAND_W   = 8;
  localparam int GAIN_W   = 9;
  localparam int MAG_W    = 13;
  localparam int TAB_FRAC = 24;
  localparam int TAB_W    = 25;

  // Root widths: sqrt(m * 2^2F) and sqrt(m * s * 2^F).
  localparam int S_W    = (COEF_BITS + 2 * FRAC_BITS + 1) / 2;
  localparam int P_W    = COEF_BITS + S_W;
  localparam int R_W    = (P_W + FRAC_BITS + 1) / 2;
  localparam int R_LO   = R_W / 2;
  localparam int R_HI   = R_W - R_LO;
  localparam int G_W    = R_W + TAB_W;
  localparam int LIM_W  = $clog2(QUANT_MAX + 1) + FRAC_BITS + 1;
  localparam int WIDE_W = G_W + LIM_W;
  localparam int RAD1_W = 2 * S_W;
  localparam int RAD2_W = 2 * R_W;

  // Exponent handling: t = 3 * (band - gain) + 1024, shift d = 88 - t / 16.
  localparam int D_W        = 8;
  localparam int T_W        = 12;
  localparam int DIFF_W     = 10;
  localparam int EXP_BIAS   = 1024;
  localparam int SHIFT_BIAS = TAB_FRAC + 64;

  localparam logic [LIM_W-1:0] Y_LIMIT =
      LIM_W'(longint'(QUANT_MAX + 1) << FRAC_BITS);
  localparam logic [FRAC_BITS-1:0] ROUND_ADD =
      FRAC_BITS'(((longint'(4054) << FRAC_BITS) + 5000) / 10000);

  typedef struct packed {
    logic [COEF_BITS-1:0] m;
    logic                 neg;
    logic [3:0]           k;
    logic signed [D_W-1:0] d;
  } item_t;

  typedef struct packed {
    logic [R_W+1:0] rem;
    logic [R_W-1:0] root;
  } sq_t;

  // One digit of a restoring square root.
  function automatic sq_t sq_step(sq_t cur, logic [1:0] bits);
    sq_t            nxt;
    logic [R_W+1:0] rem_s;
    logic [R_W+1:0] trial;
    rem_s = {cur.rem[R_W-1:0], bits};
    trial = {cur.root, 2'b01};
    if (rem_s >= trial) begin
      nxt.rem  = rem_s - trial;
      nxt.root = {cur.root[R_W-2:0], 1'b1};
    end else begin
      nxt.rem  = rem_s;
      nxt.root = {cur.root[R_W-2:0], 1'b0};
    end
    return nxt;
  endfunction

  // round(2^(k/16) * 2^24)
  function automatic logic [TAB_W-1:0] pow2_tab(logic [3:0] k);
    logic [TAB_W-1:0] v;
    case (k)
      4'd0:    v = 25'd16777216;
      4'd1:    v = 25'd17520007;
      4'd2:    v = 25'd18295684;
      4'd3:    v = 25'd19105703;
      4'd4:    v = 25'd19951585;
      4'd5:    v = 25'd20834917;
      4'd6:    v = 25'd21757357;
      4'd7:    v = 25'd22720638;
      4'd8:    v = 25'd23726566;
      4'd9:    v = 25'd24777031;
      4'd10:   v = 25'd25874004;
      4'd11:   v = 25'd27019544;
      4'd12:   v = 25'd28215802;
      4'd13:   v = 25'd29465022;
      4'd14:   v = 25'd30769550;
      default: v = 25'd32131834;
    endcase
    return v;
  endfunction

endpackage

// ----- rtl/slq_front.sv -----
// ----------------------------------------------------------------------------
// Spectral line quantizer front end
// Splits a line into magnitude and sign and works out table index and shift.
// ----------------------------------------------------------------------------
module slq_front (
  input  logic [slq_pkg::COEF_BITS-1:0] coef_i,
  input  logic [slq_pkg::BAND_W-1:0]    band_scale_i,
  input  logic [slq_pkg::GAIN_W-1:0]    global_gain_i,
  output slq_pkg::item_t                item_o
);
  import slq_pkg::*;

  logic signed [DIFF_W-1:0] diff;
  logic signed [T_W:0]      t_full;
  logic [T_W-1:0]           t;
  logic [D_W-1:0]           t_hi;

  always_comb begin
    diff   = $signed(DIFF_W'(band_scale_i))
           - $signed({global_gain_i[GAIN_W-1], global_gain_i});
    t_full = (T_W+1)'(3) * (T_W+1)'(diff) + (T_W+1)'(EXP_BIAS);
    t      = t_full[T_W-1:0];
    t_hi   = D_W'(t[T_W-1:4]);
    item_o.neg = coef_i[COEF_BITS-1];
    item_o.m   = coef_i[COEF_BITS-1] ? (~coef_i + COEF_BITS'(1)) : coef_i;
    item_o.k   = t[3:0];
    item_o.d   = $signed(D_W'(SHIFT_BIAS) - t_hi);
  end

endmodule

// ----- rtl/slq_fifo.sv -----
// ----------------------------------------------------------------------------
// Spectral line quantizer queue
// Two-entry queue between the front end and the arithmetic pipeline.
// ----------------------------------------------------------------------------
module slq_fifo (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           push_i,
  input  slq_pkg::item_t item_i,
  output logic           full_o,
  input  logic           pop_i,
  output logic           vld_o,
  output slq_pkg::item_t item_o
);
  import slq_pkg::*;

  item_t      mem_q [2];
  logic       wr_q, wr_d;
  logic       rd_q, rd_d;
  logic [1:0] cnt_q, cnt_d;
  logic       do_push, do_pop;

  assign full_o  = cnt_q[1];
  assign vld_o   = cnt_q != 2'd0;
  assign item_o  = mem_q[rd_q];
  assign do_push = push_i & ~full_o;
  assign do_pop  = pop_i & vld_o;

  always_comb begin
    wr_d  = wr_q ^ do_push;
    rd_d  = rd_q ^ do_pop;
    cnt_d = cnt_q + {1'b0, do_push} - {1'b0, do_pop};
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= 1'b0;
      rd_q  <= 1'b0;
      cnt_q <= 2'd0;
    end else begin
      wr_q  <= wr_d;
      rd_q  <= rd_d;
      cnt_q <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_q] <= item_i;
    end
  end

endmodule

// ----- rtl/slq_back.sv -----
// ----------------------------------------------------------------------------
// Spectral line quantizer back end
// Pipelined roots, power-of-two scaling, rounding and saturation.
// ----------------------------------------------------------------------------
module slq_back (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       in_vld_i,
  input  slq_pkg::item_t             item_i,
  output logic                       pop_o,
  output logic                       out_vld_o,
  input  logic                       out_rdy_i,
  output logic [slq_pkg::MAG_W-1:0]  mag_o,
  output logic                       neg_o,
  output logic                       clip_o
);
  import slq_pkg::*;

  logic en;

  logic  s1_vld_q [S_W+1];
  item_t s1_it_q  [S_W+1];
  sq_t   s1_sq_q  [S_W+1];

  logic           s2_vld_q [R_W+1];
  item_t          s2_it_q  [R_W+1];
  sq_t            s2_sq_q  [R_W+1];
  logic [P_W-1:0] s2_p_q   [R_W+1];

  logic                    mv_vld_q;
  item_t                   mv_it_q;
  logic [R_LO+TAB_W-1:0]   lo_q;
  logic [R_HI+TAB_W-1:0]   hi_q;
  logic                    g_vld_q;
  item_t                   g_it_q;
  logic [G_W-1:0]          g_q;
  logic                    y_vld_q;
  logic                    y_neg_q;
  logic [LIM_W-1:0]        y_q, y_d;
  logic                    o_vld_q;
  logic [MAG_W-1:0]        mag_q, mag_d;
  logic                    neg_q, clip_q, clip_d;

  logic [TAB_W-1:0]  tab;
  logic [D_W-1:0]    sh_amt;
  logic [G_W-1:0]    shr;
  logic [WIDE_W-1:0] shl;
  logic              sat;
  logic [LIM_W:0]    sum;
  logic [LIM_W-FRAC_BITS:0] magw;

  assign en        = ~o_vld_q | out_rdy_i;
  assign pop_o     = en & in_vld_i;
  assign out_vld_o = o_vld_q;
  assign mag_o     = mag_q;
  assign neg_o     = neg_q;
  assign clip_o    = clip_q;

  // Valid bits of every stage.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i <= S_W; i++) s1_vld_q[i] <= 1'b0;
      for (int i = 0; i <= R_W; i++) s2_vld_q[i] <= 1'b0;
      mv_vld_q <= 1'b0;
      g_vld_q  <= 1'b0;
      y_vld_q  <= 1'b0;
      o_vld_q  <= 1'b0;
    end else if (en) begin
      s1_vld_q[0] <= in_vld_i;
      for (int i = 0; i < S_W; i++) s1_vld_q[i+1] <= s1_vld_q[i];
      s2_vld_q[0] <= s1_vld_q[S_W];
      for (int i = 0; i < R_W; i++) s2_vld_q[i+1] <= s2_vld_q[i];
      mv_vld_q <= s2_vld_q[R_W];
      g_vld_q  <= mv_vld_q;
      y_vld_q  <= g_vld_q;
      o_vld_q  <= y_vld_q;
    end
  end

  // First root: sqrt(m) in Q.F, one result bit per stage.
  always_ff @(posedge clk_i) begin
    if (en) begin
      s1_it_q[0] <= item_i;
      s1_sq_q[0] <= '0;
    end
  end

  for (genvar i = 0; i < S_W; i++) begin : g_sq1
    logic [RAD1_W-1:0] rad;
    assign rad = RAD1_W'({s1_it_q[i].m, {(2*FRAC_BITS){1'b0}}});
    always_ff @(posedge clk_i) begin
      if (en) begin
        s1_it_q[i+1] <= s1_it_q[i];
        s1_sq_q[i+1] <= sq_step(s1_sq_q[i], rad[2*(S_W-1-i)+1 -: 2]);
      end
    end
  end

  // m * sqrt(m), then the second root gives m^(3/4) in Q.F.
  always_ff @(posedge clk_i) begin
    if (en) begin
      s2_it_q[0] <= s1_it_q[S_W];
      s2_sq_q[0] <= '0;
      s2_p_q[0]  <= P_W'(s1_it_q[S_W].m) * P_W'(s1_sq_q[S_W].root[S_W-1:0]);
    end
  end

  for (genvar i = 0; i < R_W; i++) begin : g_sq2
    logic [RAD2_W-1:0] rad;
    assign rad = RAD2_W'({s2_p_q[i], {FRAC_BITS{1'b0}}});
    always_ff @(posedge clk_i) begin
      if (en) begin
        s2_it_q[i+1] <= s2_it_q[i];
        s2_p_q[i+1]  <= s2_p_q[i];
        s2_sq_q[i+1] <= sq_step(s2_sq_q[i], rad[2*(R_W-1-i)+1 -: 2]);
      end
    end
  end

  // Fractional power of two as two half-width products, then their sum.
  assign tab = pow2_tab(s2_it_q[R_W].k);

  always_ff @(posedge clk_i) begin
    if (en) begin
      mv_it_q <= s2_it_q[R_W];
      lo_q    <= (R_LO+TAB_W)'(s2_sq_q[R_W].root[R_LO-1:0]) * (R_LO+TAB_W)'(tab);
      hi_q    <= (R_HI+TAB_W)'(s2_sq_q[R_W].root[R_W-1:R_LO]) * (R_HI+TAB_W)'(tab);
      g_it_q  <= mv_it_q;
      g_q     <= G_W'(lo_q) + (G_W'(hi_q) << R_LO);
    end
  end

  // Whole power of two as a shift, clamped to the saturation limit.
  always_comb begin
    shr = '0;
    shl = '0;
    if (!g_it_q.d[D_W-1]) begin
      sh_amt = g_it_q.d;
      shr    = g_q >> sh_amt;
      sat    = shr > G_W'(Y_LIMIT);
    end else begin
      sh_amt = D_W'(-g_it_q.d);
      if (sh_amt > D_W'(LIM_W)) begin
        sat = g_q != '0;
      end else begin
        shl = WIDE_W'(g_q) << sh_amt;
        sat = shl > WIDE_W'(Y_LIMIT);
      end
    end
    if (sat) begin
      y_d = Y_LIMIT;
    end else if (!g_it_q.d[D_W-1]) begin
      y_d = shr[LIM_W-1:0];
    end else begin
      y_d = shl[LIM_W-1:0];
    end
  end

  // Rounding offset, truncation and saturation.
  always_comb begin
    sum    = (LIM_W+1)'(y_q) + (LIM_W+1)'(ROUND_ADD);
    magw   = sum[LIM_W:FRAC_BITS];
    clip_d = magw > (LIM_W-FRAC_BITS+1)'(QUANT_MAX);
    mag_d  = clip_d ? MAG_W'(QUANT_MAX) : magw[MAG_W-1:0];
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      y_neg_q <= g_it_q.neg;
      y_q     <= y_d;
      neg_q   <= y_neg_q;
      mag_q   <= mag_d;
      clip_q  <= clip_d;
    end
  end

endmodule

// ----- rtl/spectral_line_quantizer.sv -----
// ----------------------------------------------------------------------------
// Spectral line quantizer
// Nonuniform quantizer: |coef|^(3/4) scaled by 2^(3/16*(band-global)).
// ----------------------------------------------------------------------------
// Throughput: one word per cycle; the pipeline advances on every cycle in
// which the output register is empty or being taken.
// The two root extractions take one result bit per stage (28 and 34 stages).
// Reset: asynchronous, active low; clears all valid bits and global_gain.
module spectral_line_quantizer (
  input  logic        clk_i,
  input  logic        rst_ni,
  // Configuration port
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [1:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready,
  // Input stream
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [31:0] s_axis_tdata,   // coef [23:0], band_scale [31:24]
  // Output stream
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [15:0] m_axis_tdata    // quant_magnitude [12:0], negative [13],
                                      // clipped [14], zero [15]
);
  import slq_pkg::*;

  localparam logic [1:0] ADDR_GLOBAL_GAIN = 2'd0;

  logic [GAIN_W-1:0] gain_q;
  item_t             front_item;
  item_t             fifo_item;
  logic              fifo_full;
  logic              fifo_vld;
  logic              pop;
  logic [MAG_W-1:0]  mag;
  logic              neg;
  logic              clip;

  // The register is written in the access phase of an APB write.
  assign pready = 1'b1;
  assign prdata = (paddr == ADDR_GLOBAL_GAIN) ?
                  {{(32-GAIN_W){gain_q[GAIN_W-1]}}, gain_q} : 32'd0;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      gain_q <= '0;
    end else if (psel && penable && pwrite && paddr == ADDR_GLOBAL_GAIN) begin
      gain_q <= pwdata[GAIN_W-1:0];
    end
  end

  // The front end classifies each word as it arrives; the queue lets it keep
  // accepting for two words while the output side is stalled.
  slq_front u_front (
    .coef_i        (s_axis_tdata[COEF_BITS-1:0]),
    .band_scale_i  (s_axis_tdata[COEF_BITS +: BAND_W]),
    .global_gain_i (gain_q),
    .item_o        (front_item)
  );

  assign s_axis_tready = ~fifo_full;

  slq_fifo u_fifo (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .push_i (s_axis_tvalid),
    .item_i (front_item),
    .full_o (fifo_full),
    .pop_i  (pop),
    .vld_o  (fifo_vld),
    .item_o (fifo_item)
  );

  // The back end is a single stall domain ending in the output register.
  slq_back u_back (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .in_vld_i  (fifo_vld),
    .item_i    (fifo_item),
    .pop_o     (pop),
    .out_vld_o (m_axis_tvalid),
    .out_rdy_i (m_axis_tready),
    .mag_o     (mag),
    .neg_o     (neg),
    .clip_o    (clip)
  );

  assign m_axis_tdata = {1'b0, clip, neg, mag};

endmodule

// ----- tb/spectral_line_quantizer_tb.sv -----
// ----------------------------------------------------------------------------
// Spectral line quantizer testbench
// Streams coefficient words through the quantizer at several global gain
// settings and checks every result word against a bit-exact predictor of the
// nonuniform quantizer, with random idling on both sides and long stalls.
// ----------------------------------------------------------------------------
module spectral_line_quantizer_tb;
  timeunit 1ns;
  timeprecision 1ps;

  import slq_pkg::*;

  // Register map: the only register is the global gain at byte address 0.
  typedef enum logic [1:0] {GAIN_ADDR = 2'd0} reg_addr_e;

  localparam int IDLE_LIMIT = 5000;  // cycles without any handshake
  localparam int HOLD_LEN   = 300;   // long receiver hold-off
  localparam int TAIL_WAIT  = 80;    // longer than the pipeline latency

  typedef struct packed {
    logic [MAG_W-1:0] mag;
    logic             neg;
    logic             clip;
  } line_res_t;

  typedef struct {
    logic signed [COEF_BITS-1:0] coef;
    logic [BAND_W-1:0]           band;
    bit                          typed;
    line_res_t                   res;
  } stim_row_t;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        psel = 1'b0, penable = 1'b0, pwrite = 1'b0;
  logic [1:0]  paddr = GAIN_ADDR;
  logic [31:0] pwdata = '0;
  logic [31:0] prdata;
  logic        pready;
  logic        s_axis_tvalid = 1'b0;
  logic        s_axis_tready;
  logic [31:0] s_axis_tdata = '0;   // coef [23:0], band_scale [31:24]
  logic        m_axis_tvalid;
  logic        m_axis_tready = 1'b0;
  logic [15:0] m_axis_tdata;        // quant_magnitude [12:0], negative [13],
                                    // clipped [14], zero [15]

  spectral_line_quantizer dut (.*);

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  // Model copy of the global gain register and the queue of pending results.
  logic signed [GAIN_W-1:0] gain_shadow = '0;
  line_res_t                pending_lines[$];
  int                       mismatches = 0;
  bit                       timed_out = 1'b0;
  int                       tx_idle_pct = 0, rx_idle_pct = 0;
  int                       hold_left = 0;
  bit                       hold_req = 1'b0;

  // Typed expectation travelling alongside the directed word being offered.
  bit        row_typed = 1'b0;
  line_res_t row_res;

  // Floor square root of a wide radicand, one result bit at a time.
  function automatic logic [127:0] isqrt(logic [127:0] n);
    logic [127:0] root, trial;
    root = '0;
    for (int b = 63; b >= 0; b--) begin
      trial = root | (128'd1 << b);
      if (trial * trial <= n) root = trial;
    end
    return root;
  endfunction

  // Quantizes one line: |coef|^(3/4) * 2^(3/16*(band-gain)) + 0.4054, truncated.
  function automatic line_res_t quantize_line(logic [COEF_BITS-1:0] raw,
                                              logic [BAND_W-1:0] band,
                                              logic signed [GAIN_W-1:0] gain);
    line_res_t         res;
    logic [127:0]      mag_in, sq, cube4;
    logic [255:0]      scaled, ylim, rnd;
    logic [24:0]       tab;
    int                t, k, q, d;
    res.neg = raw[COEF_BITS-1];
    // The most negative code keeps its true magnitude in the wider vector.
    mag_in = res.neg ? 128'((~{1'b1, raw}) + 1) & ((128'd1 << COEF_BITS) - 1)
                     : 128'(raw);
    if (res.neg && raw == {1'b1, {(COEF_BITS-1){1'b0}}}) mag_in = 128'd1 << (COEF_BITS-1);
    sq    = isqrt(mag_in << (2 * FRAC_BITS));
    cube4 = isqrt((mag_in * sq) << FRAC_BITS);
    t = 3 * (int'(band) - int'(gain)) + EXP_BIAS;
    k = t % 16;
    q = t / 16 - 64;
    case (k)
      0: tab = 25'd16777216;  1: tab = 25'd17520007;  2: tab = 25'd18295684;
      3: tab = 25'd19105703;  4: tab = 25'd19951585;  5: tab = 25'd20834917;
      6: tab = 25'd21757357;  7: tab = 25'd22720638;  8: tab = 25'd23726566;
      9: tab = 25'd24777031; 10: tab = 25'd25874004; 11: tab = 25'd27019544;
      12: tab = 25'd28215802; 13: tab = 25'd29465022; 14: tab = 25'd30769550;
      default: tab = 25'd32131834;
    endcase
    scaled = 256'(cube4) * 256'(tab);
    d = TAB_FRAC - q;
    ylim = 256'(QUANT_MAX + 1) << FRAC_BITS;
    if (d >= 0) begin
      scaled = (d >= 256) ? '0 : scaled >> d;
    end else if (scaled != 0) begin
      // Any left shift this large lands far above the saturation limit.
      scaled = (-d >= 100) ? ylim : scaled << (-d);
    end
    if (scaled > ylim) scaled = ylim;
    rnd = 256'(((64'd4054 << FRAC_BITS) + 64'd5000) / 64'd10000);
    scaled = (scaled + rnd) >> FRAC_BITS;
    res.clip = scaled > QUANT_MAX;
    res.mag  = res.clip ? MAG_W'(QUANT_MAX) : MAG_W'(scaled);
    return res;
  endfunction

  // Monitor: takes the gain on register writes, forms an expectation for every
  // word accepted at the input and checks every word leaving the output.
  int quiet_cycles = 0;
  always @(posedge clk_i) begin
    line_res_t got, want;
    if (psel && penable && pwrite && pready && paddr == GAIN_ADDR)
      gain_shadow <= pwdata[GAIN_W-1:0];
    if (s_axis_tvalid && s_axis_tready && !row_typed)
      pending_lines.push_back(quantize_line(s_axis_tdata[COEF_BITS-1:0],
                                            s_axis_tdata[31:24], gain_shadow));
    if (s_axis_tvalid && s_axis_tready && row_typed)
      pending_lines.push_back(row_res);
    if (m_axis_tvalid && m_axis_tready) begin
      got = {m_axis_tdata[12:0], m_axis_tdata[13], m_axis_tdata[14]};
      if (pending_lines.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("unexpected result word %h", m_axis_tdata);
      end else begin
        want = pending_lines.pop_front();
        if (got !== want) begin
          mismatches++;
          if (mismatches <= 10)
            $display("mismatch: expected mag %0d neg %0d clip %0d, got mag %0d neg %0d clip %0d",
                     want.mag, want.neg, want.clip, got.mag, got.neg, got.clip);
        end
      end
    end
    if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready))
      quiet_cycles <= 0;
    else
      quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles >= IDLE_LIMIT && !timed_out) begin
      timed_out = 1'b1;
      $display("CHECKS FAILED");
      $finish;
    end
  end

  // Receiver: random idling, plus a long counted hold-off on request. The
  // request is taken back here once the hold-off has started.
  always @(posedge clk_i) begin
    if (hold_req && hold_left == 0) begin
      hold_req       = 1'b0;
      hold_left     <= HOLD_LEN;
      m_axis_tready <= 1'b0;
    end else if (hold_left > 0) begin
      hold_left     <= hold_left - 1;
      m_axis_tready <= 1'b0;
    end else begin
      m_axis_tready <= rst_ni && ($urandom_range(99) >= rx_idle_pct);
    end
  end

  task automatic send_line(logic [COEF_BITS-1:0] coef, logic [BAND_W-1:0] band,
                           bit typed, line_res_t res);
    if ($urandom_range(99) < tx_idle_pct) begin
      s_axis_tvalid <= 1'b0;
      do @(posedge clk_i); while ($urandom_range(99) < tx_idle_pct);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= {band, coef};
    row_typed     <= typed;
    row_res       <= res;
    do @(posedge clk_i); while (!s_axis_tready);
  endtask

  task automatic drain();
    s_axis_tvalid <= 1'b0;
    row_typed     <= 1'b0;
    @(posedge clk_i);
    while (pending_lines.size() != 0) @(posedge clk_i);
    repeat (TAIL_WAIT) @(posedge clk_i);
  endtask

  // Register write: setup phase, then access phase.
  task automatic write_gain(logic signed [GAIN_W-1:0] gain);
    psel    <= 1'b1;
    pwrite  <= 1'b1;
    paddr   <= GAIN_ADDR;
    pwdata  <= 32'(gain);
    penable <= 1'b0;
    @(posedge clk_i);
    penable <= 1'b1;
    @(posedge clk_i);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    @(posedge clk_i);
  endtask

  // Random line: varied magnitudes so that both small and clipped results occur,
  // with the band mostly near the gain where the output is in range.
  task automatic send_random_line(logic signed [GAIN_W-1:0] gain);
    logic [COEF_BITS-1:0] coef;
    int                   band;
    line_res_t            none;
    none = '0;
    case ($urandom_range(3))
      0:       coef = COEF_BITS'($urandom);
      default: coef = COEF_BITS'($urandom >> $urandom_range(8, 31));
    endcase
    if ($urandom_range(1)) coef = -coef;
    if ($urandom_range(2) == 0) begin
      band = $urandom_range(255);
    end else begin
      band = int'(gain) + $urandom_range(60) - 40;
      band = band < 0 ? 0 : (band > 255 ? 255 : band);
    end
    send_line(coef, BAND_W'(band), 1'b0, none);
  endtask

  stim_row_t directed[$];

  function automatic stim_row_t row(int coef, int band, bit typed,
                                    int mag = 0, bit neg = 0, bit clip = 0);
    stim_row_t r;
    r.coef  = COEF_BITS'(coef);
    r.band  = BAND_W'(band);
    r.typed = typed;
    r.res   = '{MAG_W'(mag), neg, clip};
    return r;
  endfunction

  initial begin
    logic signed [GAIN_W-1:0] gains[5];
    line_res_t                none;
    none = '0;
    gains = '{-9'sd256, 9'sd255, 9'sd40, 9'sd0, 9'sd0};
    gains[4] = GAIN_W'($urandom_range(511));

    repeat (2) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Directed lines at the reset gain of zero.
    directed.push_back(row(0, 0, 1, 0, 0, 0));                // zero coefficient
    directed.push_back(row(0, 255, 1, 0, 0, 0));
    directed.push_back(row(1, 0, 1, 1, 0, 0));                // unit gain path
    directed.push_back(row(-1, 0, 1, 1, 1, 0));
    directed.push_back(row(8388607, 255, 1, 8191, 0, 1));     // saturation
    directed.push_back(row(-8388608, 255, 1, 8191, 1, 1));    // most negative code
    directed.push_back(row(-8388608, 0, 0));
    directed.push_back(row(8388607, 0, 0));
    directed.push_back(row(4096, 0, 0));
    directed.push_back(row(-4096, 16, 0));
    directed.push_back(row(1000, 1, 0));
    directed.push_back(row(12345, 7, 0));
    directed.push_back(row(2, 15, 0));
    directed.push_back(row(-5592405, 8, 0));                  // alternating bits
    directed.push_back(row(5592405, 3, 0));
    directed.push_back(row(-2796203, 5, 0));
    directed.push_back(row(170, 170, 0));
    directed.push_back(row(85, 85, 0));
    foreach (directed[i])
      send_line(directed[i].coef, directed[i].band, directed[i].typed, directed[i].res);
    drain();

    // A tiny scale under the most positive gain shifts everything away.
    write_gain(9'sd255);
    send_line(COEF_BITS'(1), 8'd0, 1'b1, '{MAG_W'(0), 1'b0, 1'b0});
    send_line(COEF_BITS'(8388607), 8'd0, 1'b0, none);
    drain();

    for (int ph = 0; ph < 5; ph++) begin
      // Idling: sender 27 / receiver 51 first, then swapped, then none.
      if (ph < 2) begin
        tx_idle_pct = 27; rx_idle_pct = 51;
      end else if (ph < 4) begin
        tx_idle_pct = 51; rx_idle_pct = 27;
      end else begin
        tx_idle_pct = 0; rx_idle_pct = 0;
      end
      write_gain(gains[ph]);
      for (int n = 0; n < 100; n++) begin
        if (ph == 1 && n == 30) hold_req = 1'b1;   // fill the pipeline and stall
        if (ph == 3 && n == 50) begin
          // Sender pauses until every outstanding word has come back.
          s_axis_tvalid <= 1'b0;
          @(posedge clk_i);
          while (pending_lines.size() != 0) @(posedge clk_i);
        end
        send_random_line(gains[ph]);
      end
      drain();
    end

    if (mismatches == 0 && pending_lines.size() == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule
